// ===== hw/rtl/rlpbe_pkg.sv =====
// Shared types, constants and the hue wheel lookup for the RGB LED bit encoder.
package rlpbe_pkg;

  localparam int unsigned WHEEL_STEPS    = 1536;
  localparam int unsigned MAX_SLOTS      = 64;
  localparam int unsigned BITS_PER_PIXEL = 24;
  localparam int unsigned HUE_W          = 11;
  localparam int unsigned SLOT_W         = 7;
  localparam int unsigned DUTY_W         = 16;

  localparam logic [15:0] DUTY_ONE_RST    = 16'd192;
  localparam logic [15:0] DUTY_ZERO_RST   = 16'd96;
  localparam logic [6:0]  RESET_SLOTS_RST = 7'd42;
  localparam logic [10:0] HUE_STEP_RST    = 11'd192;

  typedef enum logic [1:0] {
    REQ_EXPLICIT = 2'd0,
    REQ_RAINBOW  = 2'd1,
    REQ_EOF      = 2'd2,
    REQ_NONE     = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_DUTY_ONE    = 2'd0,
    CFG_DUTY_ZERO   = 2'd1,
    CFG_RESET_SLOTS = 2'd2,
    CFG_HUE_STEP    = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PIXEL   = 2'd1,
    ST_TRAILER = 2'd2,
    ST_SETTLE  = 2'd3
  } state_t;

  // Request to the shared modular adder: result = (a + b) mod WHEEL_STEPS.
  typedef struct packed {
    logic              start;
    logic [HUE_W-1:0]  a;
    logic [HUE_W-1:0]  b;
  } hue_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [HUE_W-1:0]  result;
  } hue_stat_t;

  // Six-segment hue wheel, returned as a GRB word. The position is below WHEEL_STEPS.
  function automatic logic [23:0] wheel_colour(input logic [HUE_W-1:0] pos);
    logic [7:0] f;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    f = pos[7:0];
    case (pos[10:8])
      3'd0: begin r = 8'hFF;     g = f;         b = 8'h00;     end
      3'd1: begin r = 8'hFF - f; g = 8'hFF;     b = 8'h00;     end
      3'd2: begin r = 8'h00;     g = 8'hFF;     b = f;         end
      3'd3: begin r = 8'h00;     g = 8'hFF - f; b = 8'hFF;     end
      3'd4: begin r = f;         g = 8'h00;     b = 8'hFF;     end
      default: begin r = 8'hFF;  g = 8'h00;     b = 8'hFF - f; end
    endcase
    return {g, r, b};
  endfunction

endpackage

// ===== hw/rtl/rlpbe_if.sv =====
// Valid/ready stream interfaces for pixel requests and duty slots.
interface rlpbe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, req_type, red, green, blue, input ready);
  modport sink (input valid, req_type, red, green, blue, output ready);
endinterface

interface rlpbe_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty;
  logic        is_reset;
  logic        last;

  modport source (output valid, duty, is_reset, last, input ready);
  modport sink (input valid, duty, is_reset, last, output ready);
endinterface

// ===== hw/rtl/rgb_led_pwm_bit_encoder.sv =====
// Top level of the RGB LED pixel stream encoder with hue wheel colour source.
// Each accepted pixel request produces 24 duty slots (green, red, blue, MSB first), one per
// cycle while the sink is ready; the next request is taken in the cycle the last slot of
// the current one leaves. An end-of-frame request produces min(reset_slots, 64) zero-duty
// trailer slots. Rainbow pixels and end-of-frame requests after rainbow pixels use a shared
// modular adder; it overlaps the slot output, so only an end-of-frame whose trailer ends
// before the adder is done holds off the next request until the adder is done.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must write it
// only while no request is in progress, as the block itself does not enforce this.
module rgb_led_pwm_bit_encoder (
  input  logic        clk,
  input  logic        rst,
  rlpbe_in_if.sink    pix_in,
  rlpbe_out_if.source slot_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rlpbe_pkg::state_t    state;
  rlpbe_pkg::state_t    state_next;
  rlpbe_pkg::req_type_t req;
  rlpbe_pkg::hue_req_t  hue_req;
  rlpbe_pkg::hue_stat_t hue_stat;

  logic [15:0] duty_one;
  logic [15:0] duty_zero;
  logic [6:0]  reset_slots;
  logic [10:0] hue_step;

  logic [10:0] effect_time;
  logic [10:0] hue_position;
  logic        rainbow_used;
  logic        hue_to_effect;

  logic [23:0] word;
  logic [6:0]  slot_cnt;
  logic [6:0]  trail_len;
  logic [6:0]  trail_n;

  logic out_fire;
  logic is_last;
  logic finish;
  logic accept;

  rlpbe_hue_mod u_hue_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (hue_req),
    .stat (hue_stat)
  );

  assign req      = rlpbe_pkg::req_type_t'(pix_in.req_type);
  assign trail_n  = (reset_slots > 7'(rlpbe_pkg::MAX_SLOTS)) ?
                    7'(rlpbe_pkg::MAX_SLOTS) : reset_slots;
  assign out_fire = slot_out.valid && slot_out.ready;
  assign is_last  = (state == rlpbe_pkg::ST_TRAILER) ? (slot_cnt == trail_len - 7'd1) :
                    (slot_cnt == 7'(rlpbe_pkg::BITS_PER_PIXEL - 1));
  assign finish   = out_fire && is_last;

  assign pix_in.ready = (state == rlpbe_pkg::ST_IDLE) || (finish && !hue_stat.busy);
  assign accept       = pix_in.valid && pix_in.ready;

  assign slot_out.valid    = (state == rlpbe_pkg::ST_PIXEL) || (state == rlpbe_pkg::ST_TRAILER);
  assign slot_out.is_reset = (state == rlpbe_pkg::ST_TRAILER);
  assign slot_out.last     = is_last;
  assign slot_out.duty     = (state == rlpbe_pkg::ST_TRAILER) ? '0 :
                             (word[23] ? duty_one : duty_zero);

  always_comb begin
    state_next = state;
    hue_req    = '0;
    unique case (state)
      rlpbe_pkg::ST_IDLE: begin
      end
      rlpbe_pkg::ST_PIXEL, rlpbe_pkg::ST_TRAILER: begin
        if (finish) begin
          state_next = hue_stat.busy ? rlpbe_pkg::ST_SETTLE : rlpbe_pkg::ST_IDLE;
        end
      end
      rlpbe_pkg::ST_SETTLE: begin
        if (!hue_stat.busy) begin
          state_next = rlpbe_pkg::ST_IDLE;
        end
      end
    endcase
    if (accept) begin
      unique case (req)
        rlpbe_pkg::REQ_EXPLICIT: begin
          state_next = rlpbe_pkg::ST_PIXEL;
        end
        rlpbe_pkg::REQ_RAINBOW: begin
          state_next    = rlpbe_pkg::ST_PIXEL;
          hue_req.start = 1'b1;
          hue_req.a     = hue_position;
          hue_req.b     = hue_step;
        end
        rlpbe_pkg::REQ_EOF: begin
          if (rainbow_used) begin
            hue_req.start = 1'b1;
            hue_req.a     = effect_time;
            hue_req.b     = 11'd1;
          end
          if (trail_n != 7'd0) begin
            state_next = rlpbe_pkg::ST_TRAILER;
          end else begin
            state_next = rainbow_used ? rlpbe_pkg::ST_SETTLE : rlpbe_pkg::ST_IDLE;
          end
        end
        rlpbe_pkg::REQ_NONE: begin
          state_next = rlpbe_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlpbe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_one    <= rlpbe_pkg::DUTY_ONE_RST;
      duty_zero   <= rlpbe_pkg::DUTY_ZERO_RST;
      reset_slots <= rlpbe_pkg::RESET_SLOTS_RST;
      hue_step    <= rlpbe_pkg::HUE_STEP_RST;
    end else if (cfg_we) begin
      unique case (rlpbe_pkg::cfg_index_t'(cfg_index))
        rlpbe_pkg::CFG_DUTY_ONE:    duty_one    <= cfg_data;
        rlpbe_pkg::CFG_DUTY_ZERO:   duty_zero   <= cfg_data;
        rlpbe_pkg::CFG_RESET_SLOTS: reset_slots <= cfg_data[6:0];
        rlpbe_pkg::CFG_HUE_STEP:    hue_step    <= cfg_data[10:0];
      endcase
    end
  end

  // Frame state. The adder result lands in the hue position, and also in the effect time
  // when it was started by an end of frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      effect_time   <= '0;
      hue_position  <= '0;
      rainbow_used  <= 1'b0;
      hue_to_effect <= 1'b0;
    end else begin
      if (hue_stat.done) begin
        hue_position <= hue_stat.result;
        if (hue_to_effect) begin
          effect_time <= hue_stat.result;
        end
      end
      if (accept && req == rlpbe_pkg::REQ_RAINBOW) begin
        rainbow_used  <= 1'b1;
        hue_to_effect <= 1'b0;
      end
      if (accept && req == rlpbe_pkg::REQ_EOF) begin
        rainbow_used  <= 1'b0;
        hue_to_effect <= 1'b1;
        if (!rainbow_used) begin
          hue_position <= effect_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_cnt  <= '0;
      trail_len <= trail_n;
      if (req == rlpbe_pkg::REQ_RAINBOW) begin
        word <= rlpbe_pkg::wheel_colour(hue_position);
      end else begin
        word <= {pix_in.green, pix_in.red, pix_in.blue};
      end
    end else if (out_fire) begin
      slot_cnt <= slot_cnt + 7'd1;
      word     <= {word[22:0], 1'b0};
    end
  end

  a_idle_adder_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == rlpbe_pkg::ST_IDLE) |-> !hue_stat.busy)
    else $error("hue adder still busy while idle");

  a_hue_in_range: assert property (@(posedge clk) disable iff (rst)
    hue_position < 11'(rlpbe_pkg::WHEEL_STEPS))
    else $error("hue position outside the wheel");

  a_effect_in_range: assert property (@(posedge clk) disable iff (rst)
    effect_time < 11'(rlpbe_pkg::WHEEL_STEPS))
    else $error("effect time outside the wheel");

  a_pixel_starts_slots: assert property (@(posedge clk) disable iff (rst)
    (accept && (req == rlpbe_pkg::REQ_EXPLICIT || req == rlpbe_pkg::REQ_RAINBOW))
    |=> (slot_out.valid && !slot_out.is_reset && slot_cnt == 7'd0))
    else $error("pixel request did not start its slots");

endmodule

// ===== hw/rtl/rlpbe_hue_mod.sv =====
// Shared iterative modular adder for the hue position and the effect time.
module rlpbe_hue_mod (
  input  logic                clk,
  input  logic                rst,
  input  rlpbe_pkg::hue_req_t req,
  output rlpbe_pkg::hue_stat_t stat
);

  logic        running;
  logic        done;
  logic [11:0] acc;

  // The raw sum stays below three wheel turns, so at most two subtractions follow.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
      end else if (running && acc < 12'(rlpbe_pkg::WHEEL_STEPS)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= {1'b0, req.a} + {1'b0, req.b};
    end else if (running && acc >= 12'(rlpbe_pkg::WHEEL_STEPS)) begin
      acc <= acc - 12'(rlpbe_pkg::WHEEL_STEPS);
    end
  end

  assign stat.busy   = running || done;
  assign stat.done   = done;
  assign stat.result = acc[10:0];

endmodule
